FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/cvpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpm_pkg
// Shared sizes, constants and request types of the cell voltage monitor.
// ----------------------------------------------------------------------------
package cvpm_pkg;

	localparam int CELL_COUNT    = 4;
	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 8;

	localparam int NFILT       = CELL_COUNT + 4;
	localparam int CH_W        = $clog2(NFILT);
	localparam int IDX_SUPPLY  = 0;
	localparam int IDX_CURRENT = CELL_COUNT + 1;
	localparam int IDX_PACK    = CELL_COUNT + 2;
	localparam int IDX_TEMP    = CELL_COUNT + 3;

	localparam int STATE_W   = 24;
	localparam int COEFF_W   = 16;
	localparam int LIM_W     = 13;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 3;

	// shift-add multiplier and restoring divider sizes
	localparam int MUL_A_W   = SAMPLE_BITS + STATE_W;
	localparam int MUL_B_W   = 18;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int DIV_D_W   = SAMPLE_BITS + 16;
	localparam int QUOT_W    = STATE_W;
	localparam int DSH_W     = DIV_D_W + QUOT_W - 1;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);
	localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

	localparam logic [DIV_D_W-1:0] FULL_SCALE = DIV_D_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [DIV_D_W-1:0] CELL_DIV   = FULL_SCALE << 16;
	localparam logic [DIV_D_W-1:0] PACK_DIV   = FULL_SCALE * DIV_D_W'(10000);
	localparam logic [DIV_D_W-1:0] CUR_DIV    = DIV_D_W'(1000) << FRACTION_BITS;

	localparam logic [MUL_B_W-1:0] SUPPLY_REF_MV = MUL_B_W'(3300);
	localparam logic [MUL_B_W-1:0] PACK_NUM      = MUL_B_W'(50015);
	localparam logic [MUL_B_W-1:0] CUR_NUM       = MUL_B_W'(10416);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVER_LIMIT,
		REG_UNDER_LIMIT,
		REG_OVER_RELEASE,
		REG_UNDER_RELEASE,
		REG_FILTER_COEFF,
		REG_REF_CAL,
		REG_CELL_GAIN,
		REG_CURRENT_ZERO
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_FMUL,
		ST_CLOAD,
		ST_CMUL,
		ST_CDIV,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  n;
		logic [DIV_D_W-1:0] d;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] q;
		logic              rem_nz;
	} div_rsp_t;

endpackage

FILE: hdl/cvpm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpm_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cvpm_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  cvpm_pkg::mul_req_t req,
	output cvpm_pkg::mul_rsp_t rsp
);
	import cvpm_pkg::*;

	logic [PROD_W-1:0]    acc_q;
	logic [PROD_W-1:0]    mcd_q;
	logic [MUL_B_W-1:0]   mlr_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == MUL_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcd_q <= PROD_W'(req.a);
			mlr_q <= req.b;
			cnt_q <= MUL_CNT_W'(MUL_B_W);
		end else if (run_q) begin
			if (mlr_q[0]) begin
				acc_q <= acc_q + mcd_q;
			end
			mcd_q <= mcd_q << 1;
			mlr_q <= mlr_q >> 1;
			cnt_q <= cnt_q - MUL_CNT_W'(1);
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q;

endmodule

FILE: hdl/cvpm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpm_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
// ----------------------------------------------------------------------------
module cvpm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cvpm_pkg::div_req_t req,
	output cvpm_pkg::div_rsp_t rsp
);
	import cvpm_pkg::*;

	localparam int CMP_W = PROD_W + DIV_D_W;

	logic [PROD_W-1:0]    rem_q;
	logic [DIV_D_W-1:0]   den_q;
	logic [DSH_W-1:0]     dsh_q;
	logic [QUOT_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 chk_q;
	logic                 run_q;
	logic                 done_q;
	logic                 sat;
	logic                 ge;

	// quotient would not fit: dividend at or above divisor * 2^24
	assign sat = CMP_W'(rem_q) >= (CMP_W'(den_q) << QUOT_W);
	assign ge  = rem_q >= PROD_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q  <= 1'b0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				chk_q <= 1'b1;
			end else if (chk_q) begin
				chk_q <= 1'b0;
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q && cnt_q == DIV_CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.n;
			den_q <= req.d;
		end else if (chk_q) begin
			dsh_q <= DSH_W'(den_q) << (QUOT_W - 1);
			cnt_q <= DIV_CNT_W'(QUOT_W);
			quo_q <= sat ? '1 : '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - PROD_W'(dsh_q);
			end
			quo_q <= {quo_q[QUOT_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	assign rsp.done   = done_q;
	assign rsp.q      = quo_q;
	assign rsp.rem_nz = (rem_q != '0);

endmodule

FILE: hdl/cell_voltage_protection_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_voltage_protection_monitor_unit
// Cell over/under-voltage protection with filtered supply, cell, pack,
// current and temperature readings from one ADC scan per beat.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries one scan per beat (eight 12-bit samples). m_* returns one
//  beat per scan with the flags and the filtered readings. cfg_we writes
//  register cfg_index with cfg_data in the same edge; write only when idle.
//  Each scan is worked channel by channel through one shift-add multiplier
//  and one restoring divider: supply first, then cells, current, pack and
//  temperature, then the current scaling; the supply step is skipped when
//  the reference sample is zero. s_tready is high only between scans, so
//  a new scan is taken only once the previous one has been worked through.
//  The result sits in an output register: a stalled receiver holds m_tdata
//  and the next scan is still taken and worked; it waits only at the final
//  hand-over if the previous beat is still pending.
//  Reset clears all filter states, latches and the first-scan mark, opens
//  the contactor and loads the register defaults.
// ----------------------------------------------------------------------------
module cell_voltage_protection_monitor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cell1..cellN, current, pack, temp, reference samples, lowest first
	input  logic [((cvpm_pkg::NFILT*cvpm_pkg::SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// contactor_closed, over_voltage, under_voltage, supply_mv,
	// cell1..cellN_mv, pack_mv, current_level, temp_mv, zero pad
	output logic [((cvpm_pkg::CELL_COUNT*13+61+7)/8)*8-1:0] m_tdata,
	input  logic                              cfg_we,
	input  logic [cvpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cvpm_pkg::CFG_W-1:0]        cfg_data
);
	import cvpm_pkg::*;

`include "assert_macros.svh"

	localparam int MV_W   = 13;
	localparam int PACK_W = 16;
	localparam int CUR_W  = 16;
	localparam int O_SUP  = 3;
	localparam int O_CELL = O_SUP + MV_W;
	localparam int O_PACK = O_CELL + CELL_COUNT * MV_W;
	localparam int O_CUR  = O_PACK + PACK_W;
	localparam int O_TEMP = O_CUR + CUR_W;
	localparam int OUT_W  = ((CELL_COUNT * 13 + 61 + 7) / 8) * 8;

	// configuration
	logic [LIM_W-1:0]   over_limit_q, under_limit_q, over_rel_q, under_rel_q;
	logic [COEFF_W-1:0] coeff_q;
	logic [11:0]        ref_cal_q;
	logic [17:0]        gain_q;
	logic [11:0]        cur_zero_q;

	// sequencer and datapath state
	seq_state_t               state_q, state_d;
	logic [CH_W-1:0]          ch_q;
	logic [SAMPLE_BITS-1:0]   smp_q [NFILT];
	logic [STATE_W-1:0]       filt_q [NFILT];
	logic                     neg_q;
	logic [CUR_W-1:0]         lvl_q;
	logic                     any_over_q, any_under_q, all_below_q, all_above_q;
	logic                     all_inside_q;
	logic                     over_q, under_q, contactor_q, first_done_q;
	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_tdata_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// control strobes from the sequencer
	logic ch_inc, f_we, cur_we, dec, out_ld, accept;

	logic [SAMPLE_BITS-1:0] sel_smp;
	logic [STATE_W-1:0]     sel_f;
	logic                   is_cell;
	logic [STATE_W:0]       fdiff;
	logic [STATE_W:0]       cdiff;
	logic [STATE_W:0]       fdiff_abs;
	logic [STATE_W:0]       cdiff_abs;
	logic [STATE_W-1:0]     step;
	logic [STATE_W-1:0]     f_new;
	logic [QUOT_W:0]        cmag;
	logic [CUR_W-1:0]       lvl_d;
	logic                   ov_n, un_n, ct_n;
	logic [STATE_W-1:0]     ovq, unq, orq, urq;
	logic [OUT_W-1:0]       out_d;

	function automatic logic [MV_W-1:0] sat_mv(input logic [STATE_W-1:0] f);
		logic [STATE_W-FRACTION_BITS-1:0] v;
		v = f[STATE_W-1:FRACTION_BITS];
		if (32'(v) > 32'(8191)) return '1;
		return MV_W'(v);
	endfunction

	function automatic logic [PACK_W-1:0] sat_pack(input logic [STATE_W-1:0] f);
		logic [STATE_W-FRACTION_BITS-1:0] v;
		v = f[STATE_W-1:FRACTION_BITS];
		if (32'(v) > 32'(65535)) return '1;
		return PACK_W'(v);
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// limits in Q.FRACTION_BITS
	assign ovq = STATE_W'({over_limit_q, {FRACTION_BITS{1'b0}}});
	assign unq = STATE_W'({under_limit_q, {FRACTION_BITS{1'b0}}});
	assign orq = STATE_W'({over_rel_q, {FRACTION_BITS{1'b0}}});
	assign urq = STATE_W'({under_rel_q, {FRACTION_BITS{1'b0}}});

	// channel 0 is the supply, fed by the reference sample (last in the beat)
	assign sel_smp = (ch_q == CH_W'(IDX_SUPPLY)) ? smp_q[NFILT-1]
		: smp_q[CH_W'(ch_q - 1'b1)];
	assign sel_f   = filt_q[ch_q];
	assign is_cell = (ch_q >= CH_W'(1)) && (ch_q <= CH_W'(CELL_COUNT));

	assign fdiff     = {1'b0, div_rsp.q} - {1'b0, sel_f};
	assign fdiff_abs = fdiff[STATE_W] ? -fdiff : fdiff;
	assign cdiff     = {1'b0, filt_q[IDX_CURRENT]}
		- (STATE_W+1)'({cur_zero_q, {FRACTION_BITS{1'b0}}});
	assign cdiff_abs = cdiff[STATE_W] ? -cdiff : cdiff;

	// filter step, floored: negative deltas round away from zero
	always_comb begin
		if (neg_q) begin
			step  = STATE_W'((mul_rsp.p + PROD_W'(16'hFFFF)) >> COEFF_W);
			f_new = sel_f - step;
		end else begin
			step  = STATE_W'(mul_rsp.p >> COEFF_W);
			f_new = sel_f + step;
		end
	end

	// current level: floor of signed quotient, then clamp to 16 bits
	always_comb begin
		cmag = (QUOT_W+1)'(div_rsp.q) + (QUOT_W+1)'(div_rsp.rem_nz);
		if (neg_q) begin
			if (cmag > (QUOT_W+1)'(32768)) lvl_d = 16'h8000;
			else lvl_d = CUR_W'((QUOT_W+1)'(0) - cmag);
		end else begin
			if (div_rsp.q > QUOT_W'(32767)) lvl_d = 16'h7FFF;
			else lvl_d = CUR_W'(div_rsp.q);
		end
	end

	// protection decision at the end of a scan
	always_comb begin
		ov_n = over_q;
		un_n = under_q;
		ct_n = contactor_q;
		if (!first_done_q) begin
			if (all_inside_q) ct_n = 1'b1;
		end else begin
			if (over_q) begin
				if (all_below_q) begin
					ct_n = 1'b1;
					ov_n = 1'b0;
				end
			end else if (any_over_q) begin
				ct_n = 1'b0;
				ov_n = 1'b1;
			end
			if (under_q) begin
				if (all_above_q) begin
					ct_n = 1'b1;
					un_n = 1'b0;
				end
			end else if (any_under_q) begin
				ct_n = 1'b0;
				un_n = 1'b1;
			end
		end
	end

	// sequencer: next state and unit requests
	always_comb begin
		state_d = state_q;
		mul_req = '0;
		div_req = '0;
		ch_inc  = 1'b0;
		f_we    = 1'b0;
		cur_we  = 1'b0;
		dec     = 1'b0;
		out_ld  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (ch_q == CH_W'(IDX_SUPPLY)) begin
					if (sel_smp == '0) begin
						ch_inc = 1'b1; // supply estimate held
					end else begin
						mul_req = '{start: 1'b1, a: MUL_A_W'(ref_cal_q), b: SUPPLY_REF_MV};
						state_d = ST_MUL1;
					end
				end else begin
					mul_req = '{start: 1'b1, a: MUL_A_W'(filt_q[IDX_SUPPLY]),
						b: MUL_B_W'(sel_smp)};
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				if (mul_rsp.done) begin
					if (ch_q == CH_W'(IDX_SUPPLY)) begin
						div_req = '{start: 1'b1, n: mul_rsp.p << FRACTION_BITS,
							d: DIV_D_W'(sel_smp)};
						state_d = ST_DIV;
					end else if (is_cell) begin
						mul_req = '{start: 1'b1, a: mul_rsp.p[MUL_A_W-1:0], b: gain_q};
						state_d = ST_MUL2;
					end else if (ch_q == CH_W'(IDX_PACK)) begin
						mul_req = '{start: 1'b1, a: mul_rsp.p[MUL_A_W-1:0], b: PACK_NUM};
						state_d = ST_MUL2;
					end else begin
						div_req = '{start: 1'b1, n: mul_rsp.p, d: FULL_SCALE};
						state_d = ST_DIV;
					end
				end
			end
			ST_MUL2: begin
				if (mul_rsp.done) begin
					div_req = '{start: 1'b1, n: mul_rsp.p,
						d: is_cell ? CELL_DIV : PACK_DIV};
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					mul_req = '{start: 1'b1, a: MUL_A_W'(fdiff_abs), b: MUL_B_W'(coeff_q)};
					state_d = ST_FMUL;
				end
			end
			ST_FMUL: begin
				if (mul_rsp.done) begin
					f_we = 1'b1;
					if (ch_q == CH_W'(NFILT - 1)) begin
						state_d = ST_CLOAD;
					end else begin
						ch_inc  = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_CLOAD: begin
				mul_req = '{start: 1'b1, a: MUL_A_W'(cdiff_abs), b: CUR_NUM};
				state_d = ST_CMUL;
			end
			ST_CMUL: begin
				if (mul_rsp.done) begin
					div_req = '{start: 1'b1, n: mul_rsp.p, d: CUR_DIV};
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				if (div_rsp.done) begin
					cur_we  = 1'b1;
					dec     = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_limit_q  <= LIM_W'(3650);
			under_limit_q <= LIM_W'(2700);
			over_rel_q    <= LIM_W'(3400);
			under_rel_q   <= LIM_W'(3000);
			coeff_q       <= COEFF_W'(6554);
			ref_cal_q     <= 12'd1536;
			gain_q        <= 18'd98882;
			cur_zero_q    <= 12'd2450;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OVER_LIMIT:    over_limit_q  <= cfg_data[LIM_W-1:0];
				REG_UNDER_LIMIT:   under_limit_q <= cfg_data[LIM_W-1:0];
				REG_OVER_RELEASE:  over_rel_q    <= cfg_data[LIM_W-1:0];
				REG_UNDER_RELEASE: under_rel_q   <= cfg_data[LIM_W-1:0];
				REG_FILTER_COEFF:  coeff_q       <= cfg_data[COEFF_W-1:0];
				REG_REF_CAL:       ref_cal_q     <= cfg_data[11:0];
				REG_CELL_GAIN:     gain_q        <= cfg_data[17:0];
				REG_CURRENT_ZERO:  cur_zero_q    <= cfg_data[11:0];
				default:           ;
			endcase
		end
	end

	// filter states, latches and per-scan cell summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NFILT; i++) filt_q[i] <= '0;
			ch_q         <= '0;
			any_over_q   <= 1'b0;
			any_under_q  <= 1'b0;
			all_below_q  <= 1'b1;
			all_above_q  <= 1'b1;
			all_inside_q <= 1'b1;
			over_q       <= 1'b0;
			under_q      <= 1'b0;
			contactor_q  <= 1'b0;
			first_done_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (accept) begin
				ch_q         <= '0;
				any_over_q   <= 1'b0;
				any_under_q  <= 1'b0;
				all_below_q  <= 1'b1;
				all_above_q  <= 1'b1;
				all_inside_q <= 1'b1;
			end
			if (ch_inc) ch_q <= CH_W'(ch_q + 1'b1);
			if (f_we) begin
				filt_q[ch_q] <= f_new;
				if (is_cell) begin
					if (f_new > ovq) any_over_q <= 1'b1;
					if (f_new < unq) any_under_q <= 1'b1;
					if (!(f_new < orq)) all_below_q <= 1'b0;
					if (!(f_new > urq)) all_above_q <= 1'b0;
					if (!(f_new < ovq && f_new > unq)) all_inside_q <= 1'b0;
				end
			end
			if (dec) begin
				over_q       <= ov_n;
				under_q      <= un_n;
				contactor_q  <= ct_n;
				first_done_q <= 1'b1;
			end
			if (out_ld) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NFILT; i++) smp_q[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
		end
		if (state_q == ST_DIV || state_q == ST_CLOAD) begin
			neg_q <= (state_q == ST_DIV) ? fdiff[STATE_W] : cdiff[STATE_W];
		end
		if (cur_we) lvl_q <= lvl_d;
		if (out_ld) m_tdata_q <= out_d;
	end

	// result beat assembly
	always_comb begin
		out_d = '0;
		out_d[0] = contactor_q;
		out_d[1] = over_q;
		out_d[2] = under_q;
		out_d[O_SUP +: MV_W] = sat_mv(filt_q[IDX_SUPPLY]);
		for (int i = 0; i < CELL_COUNT; i++) begin
			out_d[O_CELL + i*MV_W +: MV_W] = sat_mv(filt_q[1 + i]);
		end
		out_d[O_PACK +: PACK_W] = sat_pack(filt_q[IDX_PACK]);
		out_d[O_CUR +: CUR_W]   = lvl_q;
		out_d[O_TEMP +: MV_W]   = sat_mv(filt_q[IDX_TEMP]);
	end

	cvpm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	cvpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// unit results only turn up while the sequencer waits for them
	`ASSERT_CLK(a_mul_done_wait, mul_rsp.done |-> (state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_FMUL || state_q == ST_CMUL), "multiplier result outside a wait state")
	`ASSERT_CLK(a_div_done_wait, div_rsp.done |-> (state_q == ST_DIV || state_q == ST_CDIV), "divider result outside a wait state")
	`ASSERT_CLK(a_one_scan, accept |=> !s_tready, "second scan taken while one is in work")
	`ASSERT_CLK(a_out_from_seq, $rose(m_tvalid_q) |-> $past(state_q) == ST_OUT, "result beat raised outside hand-over")

endmodule
